@@ hdl/lscs_pkg.sv @@
package lscs_pkg;

  localparam int unsigned NumSensors = 8;
  localparam int unsigned SampleBits = 10;
  localparam int unsigned MinBits    = SampleBits + 1;
  localparam int unsigned DutyBits   = 8;
  localparam int unsigned PeriodBits = 8;

  localparam logic [MinBits-1:0]    MinReset    = MinBits'(1) << SampleBits;
  localparam logic [PeriodBits-1:0] PeriodReset = PeriodBits'(200);
  localparam logic [DutyBits-1:0]   HeldReset   = DutyBits'(110);

  // pct / 100 == pct * 5243 >> 19, exact for every product below 43690
  localparam int unsigned DivShift = 19;
  localparam int unsigned KBits    = 18;
  localparam int unsigned ProdBits = PeriodBits + KBits;

  localparam logic [KBits-1:0] KPct5  = KBits'(5 * 5243);
  localparam logic [KBits-1:0] KPct10 = KBits'(10 * 5243);
  localparam logic [KBits-1:0] KPct15 = KBits'(15 * 5243);
  localparam logic [KBits-1:0] KPct20 = KBits'(20 * 5243);
  localparam logic [KBits-1:0] KPct35 = KBits'(35 * 5243);
  localparam logic [KBits-1:0] KPct40 = KBits'(40 * 5243);

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_STEER  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    RULE_FAR_LEFT  = 4'd0,
    RULE_LEFT      = 4'd1,
    RULE_MID_LEFT  = 4'd2,
    RULE_CTR_LEFT  = 4'd3,
    RULE_FAR_RIGHT = 4'd4,
    RULE_RIGHT     = 4'd5,
    RULE_MID_RIGHT = 4'd6,
    RULE_CTR_RIGHT = 4'd7,
    RULE_CENTER    = 4'd8,
    RULE_NONE      = 4'd9
  } rule_e;

  typedef logic [NumSensors-1:0][SampleBits-1:0] samples_t;

  typedef struct packed {
    func_e                 func;
    logic [SampleBits-1:0] sensor_0;
    logic [SampleBits-1:0] sensor_1;
    logic [SampleBits-1:0] sensor_2;
    logic [SampleBits-1:0] sensor_3;
    logic [SampleBits-1:0] sensor_4;
    logic [SampleBits-1:0] sensor_5;
    logic [SampleBits-1:0] sensor_6;
    logic [SampleBits-1:0] sensor_7;
  } in_t;

  typedef struct packed {
    logic [DutyBits-1:0]   duty_left;
    logic [DutyBits-1:0]   duty_right;
    rule_e                 rule_hit;
    logic [NumSensors-1:0] above_bits;
  } out_t;

  typedef struct packed {
    logic  fire;
    func_e func;
  } step_t;

  function automatic logic [KBits-1:0] k_left(rule_e r);
    logic [KBits-1:0] k;
    unique case (r)
      RULE_FAR_LEFT:  k = KPct5;
      RULE_LEFT:      k = KPct10;
      RULE_MID_LEFT:  k = KPct15;
      RULE_CTR_LEFT:  k = KPct20;
      RULE_FAR_RIGHT: k = KPct35;
      default:        k = KPct40;
    endcase
    return k;
  endfunction

  function automatic logic [KBits-1:0] k_right(rule_e r);
    logic [KBits-1:0] k;
    unique case (r)
      RULE_FAR_LEFT:  k = KPct35;
      RULE_FAR_RIGHT: k = KPct5;
      RULE_RIGHT:     k = KPct10;
      RULE_MID_RIGHT: k = KPct15;
      RULE_CTR_RIGHT: k = KPct20;
      default:        k = KPct40;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/lscs_cal.sv @@
module lscs_cal import lscs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  step_t                 step_i,
  input  samples_t              samples_i,
  output logic [NumSensors-1:0] above_o,
  output logic [NumSensors-1:0] gt_o,
  output logic [NumSensors-1:0] lt_o
);

  logic [NumSensors-1:0][MinBits-1:0]    min_q, min_d;
  logic [NumSensors-1:0][SampleBits-1:0] max_q, max_d;
  logic [NumSensors-1:0][SampleBits-1:0] thresh_q, thresh_d;
  logic [MinBits:0]                      sum;

  always_comb begin
    min_d    = min_q;
    max_d    = max_q;
    thresh_d = thresh_q;
    sum      = '0;
    for (int i = 0; i < NumSensors; i++) begin
      gt_o[i]    = samples_i[i] > thresh_q[i];
      lt_o[i]    = samples_i[i] < thresh_q[i];
      above_o[i] = gt_o[i];
    end
    if (step_i.fire) begin
      unique case (step_i.func)
        FUNC_START: begin
          for (int i = 0; i < NumSensors; i++) begin
            min_d[i] = MinReset;
            max_d[i] = '0;
          end
        end
        FUNC_SAMPLE: begin
          for (int i = 0; i < NumSensors; i++) begin
            if (samples_i[i] > max_q[i]) max_d[i] = samples_i[i];
            if (MinBits'(samples_i[i]) < min_q[i]) min_d[i] = MinBits'(samples_i[i]);
          end
        end
        FUNC_FINISH: begin
          for (int i = 0; i < NumSensors; i++) begin
            sum         = (MinBits + 1)'(min_q[i]) + (MinBits + 1)'(max_q[i]);
            thresh_d[i] = sum[SampleBits:1];
          end
        end
        FUNC_STEER: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= {NumSensors{MinReset}};
      max_q    <= '0;
      thresh_q <= '0;
    end else begin
      min_q    <= min_d;
      max_q    <= max_d;
      thresh_q <= thresh_d;
    end
  end

  a_start_resets_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.func == FUNC_START |=> min_q == {NumSensors{MinReset}} && max_q == '0)
    else $error("min/max not reset by start");

  a_thresh_only_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i.fire && step_i.func == FUNC_FINISH) |=> $stable(thresh_q))
    else $error("threshold changed outside finish");

  a_sample_tracks_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.func == FUNC_SAMPLE |=> max_q[0] >= $past(samples_i[0]))
    else $error("max not tracking sample");

endmodule

@@ hdl/lscs_steer.sv @@
module lscs_steer import lscs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  step_t                 step_i,
  input  logic [PeriodBits-1:0] period_i,
  input  logic [NumSensors-1:0] gt_i,
  input  logic [NumSensors-1:0] lt_i,
  output rule_e                 rule_o,
  output logic [DutyBits-1:0]   left_o,
  output logic [DutyBits-1:0]   right_o
);

  logic [DutyBits-1:0] left_q, left_d, right_q, right_d;
  logic [ProdBits-1:0] prod_l, prod_r;

  always_comb begin
    rule_o = RULE_NONE;
    if (step_i.func == FUNC_STEER) begin
      priority if (gt_i[0])             rule_o = RULE_FAR_LEFT;
      else if (gt_i[1])                 rule_o = RULE_LEFT;
      else if (gt_i[2])                 rule_o = RULE_MID_LEFT;
      else if (gt_i[3] && lt_i[4])      rule_o = RULE_CTR_LEFT;
      else if (gt_i[7])                 rule_o = RULE_FAR_RIGHT;
      else if (gt_i[6])                 rule_o = RULE_RIGHT;
      else if (gt_i[5])                 rule_o = RULE_MID_RIGHT;
      else if (gt_i[4] && lt_i[3])      rule_o = RULE_CTR_RIGHT;
      else if (gt_i[3] && gt_i[4])      rule_o = RULE_CENTER;
      else                              rule_o = RULE_NONE;
    end
  end

  always_comb begin
    prod_l  = ProdBits'(period_i) * ProdBits'(k_left(rule_o));
    prod_r  = ProdBits'(period_i) * ProdBits'(k_right(rule_o));
    left_d  = left_q;
    right_d = right_q;
    if (step_i.fire && rule_o != RULE_NONE) begin
      left_d  = DutyBits'(prod_l >> DivShift);
      right_d = DutyBits'(prod_r >> DivShift);
    end
  end

  assign left_o  = left_d;
  assign right_o = right_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= HeldReset;
      right_q <= HeldReset;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  a_no_rule_off_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.func != FUNC_STEER |-> rule_o == RULE_NONE)
    else $error("rule hit on non-steer beat");

  a_hold_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i.fire || rule_o == RULE_NONE |=> $stable(left_q) && $stable(right_q))
    else $error("held duty changed without rule match");

  a_center_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && rule_o == RULE_CENTER |=> left_q == right_q)
    else $error("center rule duties differ");

endmodule

@@ hdl/line_sensor_calibrate_and_steer.sv @@
// Line sensor calibration and steering.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat carries a function
// code and eight 10-bit samples. Start clears the per-channel min/max, sample
// tracks them, finish sets each threshold to (min+max)/2, steer picks a duty
// pair from a nine-rule priority chain and scales it by the PWM period.
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one beat per
// input beat, in order: held duties, matched rule (9 for none) and the bits of
// samples above their thresholds as they stood before the beat.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes the PWM period,
// always ready; write it only while no beat is in flight.
// Path: input accept, then the input register, then the result register, to
// output valid. Throughput: one beat per cycle while out_ready_i is high, set
// by the single compare/priority/multiply stage between the two registers.
// Stall: the result register holds while out_ready_i is low; one more beat
// sits in the input register, then in_ready_o drops.
// Reset: min 1024, max and thresholds 0, held duties 110, period 200, both
// pipeline registers empty.
module line_sensor_calibrate_and_steer import lscs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [PeriodBits-1:0] cfg_data_i
);

  logic                  in_valid_q, out_valid_q, advance;
  in_t                   in_q;
  out_t                  out_q;
  logic [PeriodBits-1:0] period_q;
  samples_t              samples;
  step_t                 step;
  logic [NumSensors-1:0] above, gt, lt;
  rule_e                 rule;
  logic [DutyBits-1:0]   duty_l, duty_r;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  assign samples = {in_q.sensor_7, in_q.sensor_6, in_q.sensor_5, in_q.sensor_4,
                    in_q.sensor_3, in_q.sensor_2, in_q.sensor_1, in_q.sensor_0};
  assign step.fire = advance;
  assign step.func = in_q.func;

  lscs_cal u_cal (
    .clk_i,
    .rst_ni,
    .step_i    (step),
    .samples_i (samples),
    .above_o   (above),
    .gt_o      (gt),
    .lt_o      (lt)
  );

  lscs_steer u_steer (
    .clk_i,
    .rst_ni,
    .step_i   (step),
    .period_i (period_q),
    .gt_i     (gt),
    .lt_i     (lt),
    .rule_o   (rule),
    .left_o   (duty_l),
    .right_o  (duty_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      period_q    <= PeriodReset;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance) begin
      out_q.duty_left  <= duty_l;
      out_q.duty_right <= duty_r;
      out_q.rule_hit   <= rule;
      out_q.above_bits <= above;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
